### rtl/ttc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Time tile clusterer package
// Field widths, register indexes and reset values, and the structs passed
// between the clusterer's modules.
// ----------------------------------------------------------------------------
package ttc_pkg;

   localparam int TIME_W       = 48;
   localparam int FREQ_W       = 24;
   localparam int SNR_W        = 24;
   localparam int AMP_W        = 32;
   localparam int QUAL_W       = 16;
   localparam int GAP_W        = 32;
   localparam int TCOUNT_W     = 32;
   localparam int FIRST_W      = 32;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 32;
   localparam int INDEX_BITS_DEFAULT = 32;
   localparam int RESULT_DEPTH = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_LIMIT     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SNR_THRESHOLD = CSR_INDEX_W'(1);

   localparam logic [GAP_W-1:0] GAP_LIMIT_RESET     = GAP_W'(65536);
   localparam logic [SNR_W-1:0] SNR_THRESHOLD_RESET = SNR_W'(2560);

   localparam logic [TCOUNT_W-1:0] TCOUNT_MAX = '1;

   typedef struct packed {
      logic [TIME_W-1:0] peak_time;
      logic [TIME_W-1:0] tile_start;
      logic [TIME_W-1:0] tile_end;
      logic [FREQ_W-1:0] peak_freq;
      logic [FREQ_W-1:0] freq_low;
      logic [FREQ_W-1:0] freq_high;
      logic [SNR_W-1:0]  tile_snr;
      logic [AMP_W-1:0]  amplitude_bits;
      logic [QUAL_W-1:0] quality;
      logic              last_tile;
   } tile_type;

   typedef struct packed {
      logic [TIME_W-1:0]   cluster_time;
      logic [TIME_W-1:0]   cluster_start;
      logic [TIME_W-1:0]   cluster_end;
      logic [FREQ_W-1:0]   cluster_freq;
      logic [FREQ_W-1:0]   cluster_freq_low;
      logic [FREQ_W-1:0]   cluster_freq_high;
      logic [SNR_W-1:0]    cluster_snr;
      logic [AMP_W-1:0]    cluster_amplitude;
      logic [QUAL_W-1:0]   cluster_quality;
      logic [FIRST_W-1:0]  first_tile_index;
      logic [TCOUNT_W-1:0] tile_count;
   } cluster_type;

   typedef struct packed {
      cluster_type cluster;
      logic        final_cluster;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic [GAP_W-1:0] gap_limit;
      logic [SNR_W-1:0] snr_threshold;
   } cfg_type;

endpackage
`default_nettype wire

### rtl/ttc_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Time tile clusterer merge stage
// Holds the open cluster and the tile counter, joins or opens a cluster for
// each registered tile and pushes the closed and flushed clusters.
// ----------------------------------------------------------------------------
module ttc_merge #(
   parameter int INDEX_BITS = ttc_pkg::INDEX_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire ttc_pkg::tile_type tile,
   input  wire ttc_pkg::cfg_type  cfg,
   output ttc_pkg::push_type      push
);
   import ttc_pkg::*;

   logic                  open_valid_ff, open_valid_in;
   cluster_type           open_ff, open_in;
   logic [INDEX_BITS-1:0] counter_ff, counter_in;

   logic [TIME_W:0] reach;
   logic            join_open;
   cluster_type     merged, opened;
   logic            close_emit, flush_emit;

   assign reach     = {1'b0, open_ff.cluster_end} + {{(TIME_W + 1 - GAP_W){1'b0}}, cfg.gap_limit};
   assign join_open = open_valid_ff && ({1'b0, tile.tile_start} < reach);

   always_comb begin
      merged = open_ff;
      if (open_ff.tile_count != TCOUNT_MAX) begin
         merged.tile_count = open_ff.tile_count + TCOUNT_W'(1);
      end
      if (tile.tile_end > open_ff.cluster_end) begin
         merged.cluster_end = tile.tile_end;
      end
      if (tile.tile_start < open_ff.cluster_start) begin
         merged.cluster_start = tile.tile_start;
      end
      if (tile.freq_high > open_ff.cluster_freq_high) begin
         merged.cluster_freq_high = tile.freq_high;
      end
      if (tile.freq_low < open_ff.cluster_freq_low) begin
         merged.cluster_freq_low = tile.freq_low;
      end
      if (tile.tile_snr > open_ff.cluster_snr) begin
         merged.cluster_snr       = tile.tile_snr;
         merged.cluster_amplitude = tile.amplitude_bits;
         merged.cluster_time      = tile.peak_time;
         merged.cluster_freq      = tile.peak_freq;
         merged.cluster_quality   = tile.quality;
      end
   end

   always_comb begin
      opened.cluster_time      = tile.peak_time;
      opened.cluster_start     = tile.tile_start;
      opened.cluster_end       = tile.tile_end;
      opened.cluster_freq      = tile.peak_freq;
      opened.cluster_freq_low  = tile.freq_low;
      opened.cluster_freq_high = tile.freq_high;
      opened.cluster_snr       = tile.tile_snr;
      opened.cluster_amplitude = tile.amplitude_bits;
      opened.cluster_quality   = tile.quality;
      opened.first_tile_index  = FIRST_W'(counter_ff);
      opened.tile_count        = TCOUNT_W'(1);
   end

   assign open_in    = join_open ? merged : opened;
   assign close_emit = open_valid_ff && !join_open &&
                       (open_ff.cluster_snr >= cfg.snr_threshold);
   assign flush_emit = tile.last_tile && (open_in.cluster_snr >= cfg.snr_threshold);

   always_comb begin
      push.count                = 2'd0;
      push.first.cluster        = open_in;
      push.first.final_cluster  = 1'b1;
      push.second.cluster       = open_in;
      push.second.final_cluster = 1'b1;
      if (fire) begin
         if (close_emit) begin
            push.first.cluster       = open_ff;
            push.first.final_cluster = 1'b0;
            push.count               = flush_emit ? 2'd2 : 2'd1;
         end else if (flush_emit) begin
            push.count = 2'd1;
         end
      end
   end

   assign open_valid_in = fire ? !tile.last_tile : open_valid_ff;
   assign counter_in    = !fire ? counter_ff :
                          tile.last_tile ? '0 : counter_ff + INDEX_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         open_valid_ff <= 1'b0;
         counter_ff    <= '0;
      end else begin
         open_valid_ff <= open_valid_in;
         counter_ff    <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         open_ff <= open_in;
      end
   end

   a_flush_clears : assert property (@(posedge clock) disable iff (reset)
      fire && tile.last_tile |=> !open_valid_ff && counter_ff == '0)
      else $error("flush did not clear the open cluster");

   a_two_needs_last : assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> tile.last_tile && open_valid_ff)
      else $error("two results without a flush");

   a_no_push_idle : assert property (@(posedge clock) disable iff (reset)
      !fire |-> push.count == 2'd0)
      else $error("push without a tile");

   a_open_after_fire : assert property (@(posedge clock) disable iff (reset)
      fire && !tile.last_tile |=> open_valid_ff)
      else $error("tile left no open cluster");

endmodule
`default_nettype wire

### rtl/ttc_result_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Time tile clusterer result queue
// Small queue taking up to two results per cycle and giving one beat per
// cycle on the result channel while rsp_ready is high.
// ----------------------------------------------------------------------------
module ttc_result_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ttc_pkg::push_type  push,
   output logic                    room,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output ttc_pkg::result_type     rsp_data
);
   import ttc_pkg::*;

   localparam int PTR_W = $clog2(RESULT_DEPTH);
   localparam int CNT_W = $clog2(RESULT_DEPTH + 1);

   result_type       mem_ff [RESULT_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign room      = count_ff <= CNT_W'(RESULT_DEPTH - 2);

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RESULT_DEPTH))
      else $error("result queue overflow");

   a_push_fits : assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("push into a full result queue");

   a_push_count : assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd3)
      else $error("illegal push count");

   a_count_tracks : assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 && !pop |=> count_ff == $past(count_ff) + CNT_W'(2))
      else $error("result count lost a push");

endmodule
`default_nettype wire

### rtl/time_tile_clusterer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Time tile clusterer
// Joins time-sorted time-frequency tiles into clusters by time gap and
// emits each cluster loud enough to pass the SNR threshold.
//
// Tiles enter on the req_ channel, one beat per tile; clusters leave on the
// rsp_ channel, one beat per cluster. The csr_ channel writes gap_limit
// (index 0) and snr_threshold (index 1); it is always ready. The user must
// write it only while the block is idle, which the block does not enforce.
// A tile is held in an input register, then merged with the open cluster;
// closed and flushed clusters go into a four-entry result queue, which
// feeds rsp_. One tile per cycle is taken while the queue has room for two
// results; a tile that both closes a cluster and flushes its own gives two
// beats, and the queue drains one beat per cycle while rsp_ready is high.
// When the receiver stalls the queue fills and req_ready drops; nothing is
// lost. Reset clears the open cluster, the tile index, the queue, and
// loads gap_limit 1.0 s and snr_threshold 10.0.
// ----------------------------------------------------------------------------
module time_tile_clusterer #(
   parameter int INDEX_BITS = ttc_pkg::INDEX_BITS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [ttc_pkg::TIME_W-1:0]       req_peak_time,
   input  wire logic [ttc_pkg::TIME_W-1:0]       req_tile_start,
   input  wire logic [ttc_pkg::TIME_W-1:0]       req_tile_end,
   input  wire logic [ttc_pkg::FREQ_W-1:0]       req_peak_freq,
   input  wire logic [ttc_pkg::FREQ_W-1:0]       req_freq_low,
   input  wire logic [ttc_pkg::FREQ_W-1:0]       req_freq_high,
   input  wire logic [ttc_pkg::SNR_W-1:0]        req_tile_snr,
   input  wire logic [ttc_pkg::AMP_W-1:0]        req_amplitude_bits,
   input  wire logic [ttc_pkg::QUAL_W-1:0]       req_quality,
   input  wire logic                             req_last_tile,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [ttc_pkg::TIME_W-1:0]            rsp_cluster_time,
   output logic [ttc_pkg::TIME_W-1:0]            rsp_cluster_start,
   output logic [ttc_pkg::TIME_W-1:0]            rsp_cluster_end,
   output logic [ttc_pkg::FREQ_W-1:0]            rsp_cluster_freq,
   output logic [ttc_pkg::FREQ_W-1:0]            rsp_cluster_freq_low,
   output logic [ttc_pkg::FREQ_W-1:0]            rsp_cluster_freq_high,
   output logic [ttc_pkg::SNR_W-1:0]             rsp_cluster_snr,
   output logic [ttc_pkg::AMP_W-1:0]             rsp_cluster_amplitude,
   output logic [ttc_pkg::QUAL_W-1:0]            rsp_cluster_quality,
   output logic [ttc_pkg::FIRST_W-1:0]           rsp_first_tile_index,
   output logic [ttc_pkg::TCOUNT_W-1:0]          rsp_tile_count,
   output logic                                  rsp_final_cluster,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ttc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [ttc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import ttc_pkg::*;

   logic       stage_valid_ff, stage_valid_in;
   tile_type   tile_ff;
   cfg_type    cfg_ff, cfg_in;
   push_type   push;
   result_type rsp_data;
   logic       room;
   logic       fire;
   logic       req_take;

   assign fire      = stage_valid_ff && room;
   assign req_ready = !stage_valid_ff || fire;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign stage_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : stage_valid_ff);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GAP_LIMIT:     cfg_in.gap_limit     = csr_data[GAP_W-1:0];
            CSR_SNR_THRESHOLD: cfg_in.snr_threshold = csr_data[SNR_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff       <= 1'b0;
         cfg_ff.gap_limit     <= GAP_LIMIT_RESET;
         cfg_ff.snr_threshold <= SNR_THRESHOLD_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         cfg_ff         <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         tile_ff.peak_time      <= req_peak_time;
         tile_ff.tile_start     <= req_tile_start;
         tile_ff.tile_end       <= req_tile_end;
         tile_ff.peak_freq      <= req_peak_freq;
         tile_ff.freq_low       <= req_freq_low;
         tile_ff.freq_high      <= req_freq_high;
         tile_ff.tile_snr       <= req_tile_snr;
         tile_ff.amplitude_bits <= req_amplitude_bits;
         tile_ff.quality        <= req_quality;
         tile_ff.last_tile      <= req_last_tile;
      end
   end

   ttc_merge #(
      .INDEX_BITS (INDEX_BITS)
   ) u_merge (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .tile  (tile_ff),
      .cfg   (cfg_ff),
      .push  (push)
   );

   ttc_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_cluster_time      = rsp_data.cluster.cluster_time;
   assign rsp_cluster_start     = rsp_data.cluster.cluster_start;
   assign rsp_cluster_end       = rsp_data.cluster.cluster_end;
   assign rsp_cluster_freq      = rsp_data.cluster.cluster_freq;
   assign rsp_cluster_freq_low  = rsp_data.cluster.cluster_freq_low;
   assign rsp_cluster_freq_high = rsp_data.cluster.cluster_freq_high;
   assign rsp_cluster_snr       = rsp_data.cluster.cluster_snr;
   assign rsp_cluster_amplitude = rsp_data.cluster.cluster_amplitude;
   assign rsp_cluster_quality   = rsp_data.cluster.cluster_quality;
   assign rsp_first_tile_index  = rsp_data.cluster.first_tile_index;
   assign rsp_tile_count        = rsp_data.cluster.tile_count;
   assign rsp_final_cluster     = rsp_data.final_cluster;

   a_empty_takes : assert property (@(posedge clock) disable iff (reset)
      !stage_valid_ff |-> req_ready)
      else $error("empty input stage refused a tile");

   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !room |=> stage_valid_ff && $stable(tile_ff))
      else $error("stalled tile was lost");

   a_fire_pushes_room : assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> fire)
      else $error("result pushed without a tile");

endmodule
`default_nettype wire
